>>> rtl/isc_pkg.sv
`timescale 1ns / 1ps

package isc_pkg;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ADJ  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;

	localparam logic REG_ACCEL_RANGE = 1'b0;
	localparam logic REG_GYRO_RANGE  = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [3:0] OP_SQ_X  = 4'd0;
	localparam logic [3:0] OP_SQ_Y  = 4'd1;
	localparam logic [3:0] OP_SQ_Z  = 4'd2;
	localparam logic [3:0] OP_GY_X  = 4'd3;
	localparam logic [3:0] OP_GY_Y  = 4'd4;
	localparam logic [3:0] OP_GY_Z  = 4'd5;
	localparam logic [3:0] OP_TEMP  = 4'd6;
	localparam logic [3:0] OP_DIV_X = 4'd7;
	localparam logic [3:0] OP_DIV_Y = 4'd8;
	localparam logic [3:0] OP_DIV_Z = 4'd9;
	localparam logic [3:0] OP_DRAIN = 4'd10;

	localparam int SQRT_STEPS = 19;

	localparam logic [19:0] ONE_G       = 20'd16384;
	localparam logic [18:0] ACC_POS_MAX = 19'h3FFFF;
	localparam logic [18:0] ACC_NEG_MAX = 19'h40000;
	localparam logic [25:0] SUM_POS_MAX = 26'h1FFFFFF;
	localparam logic [25:0] SUM_NEG_MAX = 26'h2000000;

	// round(raw * 64 / 85) + 32768 as floor(n / 170), n = raw * 128 + 85 + 32768 * 170
	localparam logic [24:0] TEMP_BIAS  = 25'd5570645;
	localparam logic [24:0] TEMP_RECIP = 25'd25264514;
	localparam int          TEMP_SHIFT = 32;
	localparam logic [16:0] TEMP_BASE  = 17'd23416;

	localparam logic [18:0]        MAG_MAX  = 19'd454047;
	localparam logic signed [16:0] TEMP_MIN = -17'sd15321;
	localparam logic signed [16:0] TEMP_MAX = 17'sd34024;

	function automatic logic [19:0] gyro_gain(input logic [1:0] range);
		logic [19:0] gain;
		case (range)
			2'd0: gain = 20'd128070;
			2'd1: gain = 20'd256140;
			2'd2: gain = 20'd511500;
			2'd3: gain = 20'd1023001;
			default: gain = 20'd128070;
		endcase
		return gain;
	endfunction

	function automatic logic [1:0] op_axis(input logic [3:0] op);
		logic [1:0] axis;
		case (op)
			OP_SQ_X, OP_GY_X, OP_DIV_X: axis = AXIS_X;
			OP_SQ_Y, OP_GY_Y, OP_DIV_Y: axis = AXIS_Y;
			OP_SQ_Z, OP_GY_Z, OP_DIV_Z: axis = AXIS_Z;
			default: axis = AXIS_X;
		endcase
		return axis;
	endfunction

endpackage

>>> rtl/imu_sample_scaler_calibrator.sv
// in_ready is low while an item is in work, so a new transaction is taken only
// once the previous result has moved to the output register.
// Each item passes through 3 offset steps, 11 steps of the shared multiplier,
// 19 steps of the square root and one output step.
// A finished result waits in the output register while the next item is taken.
// arst_n clears the sequencer, ranges, offsets, calibration sums and count at once.
`timescale 1ns / 1ps

module imu_sample_scaler_calibrator
	import isc_pkg::*;
#(
	parameter int CAL_SAMPLES = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [1:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [15:0] accel_x_raw,
	input  logic signed [15:0] accel_y_raw,
	input  logic signed [15:0] accel_z_raw,
	input  logic signed [15:0] temp_sample,
	input  logic signed [15:0] gyro_x_raw,
	input  logic signed [15:0] gyro_y_raw,
	input  logic signed [15:0] gyro_z_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [18:0] accel_x_g,
	output logic signed [18:0] accel_y_g,
	output logic signed [18:0] accel_z_g,
	output logic signed [19:0] gyro_x_dps,
	output logic signed [19:0] gyro_y_dps,
	output logic signed [19:0] gyro_z_dps,
	output logic signed [16:0] temp_celsius,
	output logic [18:0]        accel_norm,
	output logic               calibration_done
);

	localparam int          CAL_SHIFT   = 26 + $clog2(CAL_SAMPLES);
	localparam int          OFF_W       = 27 - $clog2(CAL_SAMPLES);
	localparam int          DIFF_W      = OFF_W + 2;
	localparam logic [63:0] CAL_RECIP_W =
		((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
	localparam logic [26:0] CAL_RECIP   = CAL_RECIP_W[26:0];
	localparam logic [7:0]  CAL_LAST    = 8'(CAL_SAMPLES);

	state_t      state_q;
	logic [1:0]  acc_range_q;
	logic [1:0]  gyr_range_q;
	logic [OFF_W-1:0] offset_q [3];
	logic [25:0] sum_q [3];
	logic [7:0]  count_q;
	logic        cal_fire_q;
	logic [1:0]  adj_q;
	logic [3:0]  op_q;
	logic [4:0]  iter_q;
	logic        out_valid_q;

	logic        command_q;
	logic [15:0] acc_raw_q [3];
	logic [15:0] gyr_raw_q [3];
	logic [15:0] temp_sample_q;
	logic [18:0] corr_q [3];
	logic signed [54:0] prod_q;
	logic [3:0]  prod_op_q;
	logic [19:0] gyr_q [3];
	logic [16:0] temp_q;
	logic [37:0] sq_q;
	logic [20:0] rem_q;
	logic [18:0] root_q;

	logic [18:0] acc_x_q, acc_y_q, acc_z_q;
	logic [19:0] gyr_x_q, gyr_y_q, gyr_z_q;
	logic [16:0] temp_out_q;
	logic [18:0] mag_q;
	logic        done_q;

	logic        accept;
	logic        out_fire;
	logic [7:0]  cnt_inc;

	logic [15:0] raw_sel;
	logic [18:0] scaled;
	logic [DIFF_W-1:0] diff;
	logic [18:0] corr_new;
	logic [19:0] add;
	logic [26:0] tot;
	logic [25:0] sum_new;

	logic [1:0]  iss_axis;
	logic [1:0]  prd_axis;
	logic [24:0] temp_ext;
	logic [25:0] div_in;
	logic signed [26:0] mul_a;
	logic signed [27:0] mul_b;
	logic signed [54:0] mul_p;
	logic [35:0] gy_round;
	logic [OFF_W-1:0] quo;

	logic [22:0] rem_sh;
	logic [22:0] trial;
	logic        ge;
	logic [22:0] rem_nx;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_fire = (state_q == ST_HOLD) && (!out_valid_q || out_ready);
	assign cnt_inc  = count_q + 8'd1;

	always_comb begin
		raw_sel = acc_raw_q[adj_q];
		scaled  = {{3{raw_sel[15]}}, raw_sel} << acc_range_q;
		diff    = {{(DIFF_W - 19){scaled[18]}}, scaled}
			- {{2{offset_q[adj_q][OFF_W-1]}}, offset_q[adj_q]};
		if (~|diff[DIFF_W-1:18] || &diff[DIFF_W-1:18]) begin
			corr_new = diff[18:0];
		end else if (diff[DIFF_W-1]) begin
			corr_new = ACC_NEG_MAX;
		end else begin
			corr_new = ACC_POS_MAX;
		end
		add = {scaled[18], scaled} - ((adj_q == AXIS_Z) ? ONE_G : 20'd0);
		tot = {sum_q[adj_q][25], sum_q[adj_q]} + {{7{add[19]}}, add};
		if (tot[26] == tot[25]) begin
			sum_new = tot[25:0];
		end else if (tot[26]) begin
			sum_new = SUM_NEG_MAX;
		end else begin
			sum_new = SUM_POS_MAX;
		end
	end

	always_comb begin
		iss_axis = op_axis(op_q);
		prd_axis = op_axis(prod_op_q);
		temp_ext = {{2{temp_sample_q[15]}}, temp_sample_q, 7'd0} + TEMP_BIAS;
		div_in   = sum_q[iss_axis][25] ? (26'd0 - sum_q[iss_axis]) : sum_q[iss_axis];
		mul_a    = '0;
		mul_b    = '0;
		case (op_q)
			OP_SQ_X, OP_SQ_Y, OP_SQ_Z: begin
				mul_a = {{8{corr_q[iss_axis][18]}}, corr_q[iss_axis]};
				mul_b = {{9{corr_q[iss_axis][18]}}, corr_q[iss_axis]};
			end
			OP_GY_X, OP_GY_Y, OP_GY_Z: begin
				mul_a = {{11{gyr_raw_q[iss_axis][15]}}, gyr_raw_q[iss_axis]};
				mul_b = {8'd0, gyro_gain(gyr_range_q)};
			end
			OP_TEMP: begin
				mul_a = {3'd0, temp_ext[23:0]};
				mul_b = {3'd0, TEMP_RECIP};
			end
			OP_DIV_X, OP_DIV_Y, OP_DIV_Z: begin
				mul_a = {1'b0, div_in};
				mul_b = {1'b0, CAL_RECIP};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign gy_round = prod_q[35:0] + 36'd32768;
	assign quo      = prod_q[CAL_SHIFT +: OFF_W];

	assign rem_sh = {rem_q, sq_q[37:36]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);
	assign rem_nx = ge ? (rem_sh - trial) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_range_q <= '0;
			gyr_range_q <= '0;
			for (int i = 0; i < 3; i++) begin
				offset_q[i] <= '0;
				sum_q[i]    <= '0;
			end
			count_q     <= '0;
			cal_fire_q  <= 1'b0;
			adj_q       <= '0;
			op_q        <= OP_SQ_X;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACCEL_RANGE: acc_range_q <= cfg_data;
					REG_GYRO_RANGE:  gyr_range_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						adj_q      <= AXIS_X;
						cal_fire_q <= 1'b0;
						if (command) begin
							if (cnt_inc == CAL_LAST) begin
								count_q    <= '0;
								cal_fire_q <= 1'b1;
							end else begin
								count_q <= cnt_inc;
							end
						end
						state_q <= ST_ADJ;
					end
				end
				ST_ADJ: begin
					if (command_q) begin
						sum_q[adj_q] <= sum_new;
					end
					if (adj_q == AXIS_Z) begin
						op_q    <= OP_SQ_X;
						state_q <= ST_MUL;
					end else begin
						adj_q <= adj_q + 2'd1;
					end
				end
				ST_MUL: begin
					if (op_q != OP_SQ_X && cal_fire_q) begin
						case (prod_op_q)
							OP_DIV_X, OP_DIV_Y, OP_DIV_Z: begin
								offset_q[prd_axis] <= sum_q[prd_axis][25]
									? ({OFF_W{1'b0}} - quo) : quo;
								sum_q[prd_axis]    <= '0;
							end
							default: ;
						endcase
					end
					if (op_q == OP_DRAIN) begin
						iter_q  <= '0;
						state_q <= ST_ROOT;
					end else begin
						op_q <= op_q + 4'd1;
					end
				end
				ST_ROOT: begin
					if (iter_q == 5'(SQRT_STEPS - 1)) begin
						state_q <= ST_HOLD;
					end else begin
						iter_q <= iter_q + 5'd1;
					end
				end
				ST_HOLD: begin
					if (out_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					command_q     <= command;
					acc_raw_q[0]  <= accel_x_raw;
					acc_raw_q[1]  <= accel_y_raw;
					acc_raw_q[2]  <= accel_z_raw;
					gyr_raw_q[0]  <= gyro_x_raw;
					gyr_raw_q[1]  <= gyro_y_raw;
					gyr_raw_q[2]  <= gyro_z_raw;
					temp_sample_q <= temp_sample;
					sq_q          <= '0;
				end
			end
			ST_ADJ: begin
				corr_q[adj_q] <= corr_new;
			end
			ST_MUL: begin
				prod_q    <= mul_p;
				prod_op_q <= op_q;
				if (op_q != OP_SQ_X) begin
					case (prod_op_q)
						OP_SQ_X, OP_SQ_Y, OP_SQ_Z: sq_q <= sq_q + prod_q[37:0];
						OP_GY_X, OP_GY_Y, OP_GY_Z: gyr_q[prd_axis] <= gy_round[35:16];
						OP_TEMP: temp_q <= prod_q[TEMP_SHIFT +: 17] - TEMP_BASE;
						default: ;
					endcase
				end
				if (op_q == OP_DRAIN) begin
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			ST_ROOT: begin
				rem_q  <= rem_nx[20:0];
				root_q <= {root_q[17:0], ge};
				sq_q   <= {sq_q[35:0], 2'b00};
			end
			ST_HOLD: begin
				if (out_fire) begin
					acc_x_q    <= corr_q[0];
					acc_y_q    <= corr_q[1];
					acc_z_q    <= corr_q[2];
					gyr_x_q    <= gyr_q[0];
					gyr_y_q    <= gyr_q[1];
					gyr_z_q    <= gyr_q[2];
					temp_out_q <= temp_q;
					mag_q      <= root_q;
					done_q     <= cal_fire_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign accel_x_g        = acc_x_q;
	assign accel_y_g        = acc_y_q;
	assign accel_z_g        = acc_z_q;
	assign gyro_x_dps       = gyr_x_q;
	assign gyro_y_dps       = gyr_y_q;
	assign gyro_z_dps       = gyr_z_q;
	assign temp_celsius     = temp_out_q;
	assign accel_norm       = mag_q;
	assign calibration_done = done_q;

endmodule

>>> rtl/isc_checker.sv
`timescale 1ns / 1ps

module isc_checker
	import isc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [16:0] temp_celsius,
	input logic [18:0]        accel_norm,
	input logic               calibration_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accel_norm)
			&& $stable(temp_celsius) && $stable(calibration_done))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("ready while a transaction is in work");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> accel_norm <= MAG_MAX)
		else $error("magnitude out of range");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temp_celsius >= TEMP_MIN && temp_celsius <= TEMP_MAX)
		else $error("temperature out of range");

endmodule

bind imu_sample_scaler_calibrator isc_checker u_isc_checker (.*);

>>> sim/isc_frame_checker.sv
`timescale 1ns / 1ps

module isc_frame_checker
	import isc_pkg::*;
#(
	parameter int CAL_RUN = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [1:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               command,
	input  logic signed [15:0] accel_x_raw,
	input  logic signed [15:0] accel_y_raw,
	input  logic signed [15:0] accel_z_raw,
	input  logic signed [15:0] temp_sample,
	input  logic signed [15:0] gyro_x_raw,
	input  logic signed [15:0] gyro_y_raw,
	input  logic signed [15:0] gyro_z_raw,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [18:0] accel_x_g,
	input  logic signed [18:0] accel_y_g,
	input  logic signed [18:0] accel_z_g,
	input  logic signed [19:0] gyro_x_dps,
	input  logic signed [19:0] gyro_y_dps,
	input  logic signed [19:0] gyro_z_dps,
	input  logic signed [16:0] temp_celsius,
	input  logic [18:0]        accel_norm,
	input  logic               calibration_done,
	output int                 errors,
	output int                 pending
);

	localparam longint ACC_HI = 262143;
	localparam longint ACC_LO = -262144;
	localparam longint SUM_HI = 33554431;
	localparam longint SUM_LO = -33554432;
	localparam longint GRAVITY = 16384;

	typedef struct packed {
		logic [18:0] ax;
		logic [18:0] ay;
		logic [18:0] az;
		logic [19:0] gx;
		logic [19:0] gy;
		logic [19:0] gz;
		logic [16:0] temp;
		logic [18:0] mag;
		logic        done;
	} scaled_frame_t;

	scaled_frame_t scaled_frames[$];
	scaled_frame_t oldest;
	logic [1:0]    acc_range;
	logic [1:0]    rate_range;
	longint        acc_offset [3];
	longint        cal_sum [3];
	int            cal_count;
	int            mismatch_reports;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic scale_and_calibrate(input logic cmd,
			input logic signed [15:0] ax, input logic signed [15:0] ay,
			input logic signed [15:0] az, input logic signed [15:0] tr,
			input logic signed [15:0] gx, input logic signed [15:0] gy,
			input logic signed [15:0] gz);
		longint raw_a [3];
		longint raw_g [3];
		longint scaled [3];
		longint corr [3];
		longint rate [3];
		longint sq;
		longint rem;
		longint root;
		longint probe;
		longint gain;
		longint tq;
		scaled_frame_t f;
		int i;
		raw_a[0] = ax;
		raw_a[1] = ay;
		raw_a[2] = az;
		raw_g[0] = gx;
		raw_g[1] = gy;
		raw_g[2] = gz;
		sq = 0;
		for (i = 0; i < 3; i++) begin
			scaled[i] = raw_a[i] <<< acc_range;
			corr[i] = clamp(scaled[i] - acc_offset[i], ACC_LO, ACC_HI);
			sq += corr[i] * corr[i];
		end
		case (rate_range)
			2'd0: gain = 128070;
			2'd1: gain = 256140;
			2'd2: gain = 511500;
			default: gain = 1023001;
		endcase
		for (i = 0; i < 3; i++)
			rate[i] = (raw_g[i] * gain + 32768) >>> 16;
		tq = (longint'(tr) * 128 + 85 + 5570560) / 170 - 32768 + 9352;
		rem = sq;
		root = 0;
		probe = 64'd1 << 40;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		f.ax = corr[0][18:0];
		f.ay = corr[1][18:0];
		f.az = corr[2][18:0];
		f.gx = rate[0][19:0];
		f.gy = rate[1][19:0];
		f.gz = rate[2][19:0];
		f.temp = tq[16:0];
		f.mag = root[18:0];
		f.done = 1'b0;
		if (cmd) begin
			for (i = 0; i < 3; i++)
				cal_sum[i] = clamp(cal_sum[i] + scaled[i] - ((i == 2) ? GRAVITY : 0),
					SUM_LO, SUM_HI);
			cal_count = (cal_count + 1) & 255;
			if (cal_count == CAL_RUN) begin
				for (i = 0; i < 3; i++) begin
					acc_offset[i] = cal_sum[i] / CAL_RUN;
					cal_sum[i] = 0;
				end
				cal_count = 0;
				f.done = 1'b1;
			end
		end
		scaled_frames.push_back(f);
	endtask

	task automatic compare_field(input string what, input logic [19:0] want,
			input logic [19:0] got);
		if (want !== got) begin
			errors++;
			if (mismatch_reports < 10)
				$display("mismatch %s: expected %h, actual %h at %0t", what, want, got, $realtime);
			mismatch_reports++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_range = 2'd0;
			rate_range = 2'd0;
			for (int i = 0; i < 3; i++) begin
				acc_offset[i] = 0;
				cal_sum[i] = 0;
			end
			cal_count = 0;
			scaled_frames.delete();
			errors = 0;
			pending = 0;
			mismatch_reports = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (scaled_frames.size() == 0) begin
					errors++;
					if (mismatch_reports < 10)
						$display("result transaction with none expected at %0t", $realtime);
					mismatch_reports++;
				end else begin
					oldest = scaled_frames.pop_front();
					compare_field("accel_x_g", oldest.ax, $unsigned(accel_x_g));
					compare_field("accel_y_g", oldest.ay, $unsigned(accel_y_g));
					compare_field("accel_z_g", oldest.az, $unsigned(accel_z_g));
					compare_field("gyro_x_dps", oldest.gx, $unsigned(gyro_x_dps));
					compare_field("gyro_y_dps", oldest.gy, $unsigned(gyro_y_dps));
					compare_field("gyro_z_dps", oldest.gz, $unsigned(gyro_z_dps));
					compare_field("temp_celsius", oldest.temp, $unsigned(temp_celsius));
					compare_field("accel_norm", oldest.mag, accel_norm);
					compare_field("calibration_done", oldest.done, calibration_done);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ACCEL_RANGE: acc_range = cfg_data;
					REG_GYRO_RANGE: rate_range = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				scale_and_calibrate(command, accel_x_raw, accel_y_raw, accel_z_raw, temp_sample,
					gyro_x_raw, gyro_y_raw, gyro_z_raw);
			pending = scaled_frames.size();
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import isc_pkg::*;

	localparam int CAL_RUN = 100;
	localparam int PHASES = 10;
	localparam int FRAMES_PER_PHASE = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic command;
	logic signed [15:0] accel_x_raw;
	logic signed [15:0] accel_y_raw;
	logic signed [15:0] accel_z_raw;
	logic signed [15:0] temp_sample;
	logic signed [15:0] gyro_x_raw;
	logic signed [15:0] gyro_y_raw;
	logic signed [15:0] gyro_z_raw;
	logic out_valid;
	logic out_ready;
	logic signed [18:0] accel_x_g;
	logic signed [18:0] accel_y_g;
	logic signed [18:0] accel_z_g;
	logic signed [19:0] gyro_x_dps;
	logic signed [19:0] gyro_y_dps;
	logic signed [19:0] gyro_z_dps;
	logic signed [16:0] temp_celsius;
	logic [18:0] accel_norm;
	logic calibration_done;
	int errors;
	int pending;

	int idle_mode;
	logic hold_req;
	int hold_left;

	always #1 clk = ~clk;

	imu_sample_scaler_calibrator #(
		.CAL_SAMPLES(CAL_RUN)
	) u_dut (.*);

	isc_frame_checker #(
		.CAL_RUN(CAL_RUN)
	) u_checker (.*);

	function automatic logic [15:0] rand_word();
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [15:0] edge_word();
		case ($urandom_range(0, 4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return rand_word();
		endcase
	endfunction

	task automatic send_frame(input logic cmd, input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] az, input logic [15:0] tr, input logic [15:0] gx,
			input logic [15:0] gy, input logic [15:0] gz);
		int pct;
		pct = (idle_mode == IDLE_SEND) ? 72 : ((idle_mode == IDLE_BOTH) ? 33 : 0);
		if ($urandom_range(0, 99) < pct) begin
			in_valid = 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < pct);
		end
		in_valid = 1'b1;
		command = cmd;
		accel_x_raw = ax;
		accel_y_raw = ay;
		accel_z_raw = az;
		temp_sample = tr;
		gyro_x_raw = gx;
		gyro_y_raw = gy;
		gyro_z_raw = gz;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_ranges(input logic [1:0] acc, input logic [1:0] rate);
		drain();
		write_reg(REG_ACCEL_RANGE, acc);
		write_reg(REG_GYRO_RANGE, rate);
	endtask

	task automatic send_pattern(input int p);
		case (p)
			0: send_frame(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
				16'h0000);
			1: send_frame(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
				16'h7FFF);
			2: send_frame(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
				16'h8000);
			3: send_frame(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
				16'hFFFF);
			4: send_frame(1'b0, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
				16'h0001);
			5: send_frame(1'b0, 16'h7FFF, 16'h8000, 16'h4000, 16'h8000, 16'h7FFF, 16'h8000,
				16'h0001);
			6: send_frame(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
				16'h7FFF);
			default: send_frame(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
				16'h8000, 16'h8000);
		endcase
	endtask

	task automatic send_random_frame();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 50)
			send_frame(1'b1, 16'($urandom_range(0, 8191) - 4096),
				16'($urandom_range(0, 8191) - 4096), 16'($urandom_range(0, 16383)),
				rand_word(), rand_word(), rand_word(), rand_word());
		else if (kind < 85)
			send_frame(1'b0, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
				rand_word(), rand_word());
		else
			send_frame(1'($urandom_range(0, 1)), edge_word(), edge_word(), edge_word(),
				edge_word(), edge_word(), edge_word(), edge_word());
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				hold_left = HOLD_CYCLES;
				while (hold_left > 0) begin
					@(negedge clk);
					hold_left--;
				end
				hold_req = 1'b0;
			end else if (idle_mode == IDLE_RECV) begin
				out_ready = ($urandom_range(0, 99) >= 72);
			end else if (idle_mode == IDLE_BOTH) begin
				out_ready = ($urandom_range(0, 99) >= 33);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ACCEL_RANGE;
		cfg_data = 2'd0;
		in_valid = 1'b0;
		command = 1'b0;
		accel_x_raw = '0;
		accel_y_raw = '0;
		accel_z_raw = '0;
		temp_sample = '0;
		gyro_x_raw = '0;
		gyro_y_raw = '0;
		gyro_z_raw = '0;
		idle_mode = IDLE_NONE;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		set_ranges(2'd0, 2'd0);
		for (int p = 0; p < 8; p++)
			send_pattern(p);
		set_ranges(2'd3, 2'd3);
		for (int p = 0; p < 8; p++)
			send_pattern(p);
		set_ranges(2'd1, 2'd2);
		for (int p = 0; p < 4; p++)
			send_pattern(p);
		set_ranges(2'd2, 2'd1);
		for (int p = 0; p < 4; p++)
			send_pattern(p);

		// run a full-scale calibration so the offsets land near full scale
		set_ranges(2'd3, 2'd3);
		for (int n = 0; n < CAL_RUN; n++)
			send_frame(1'b1, 16'h7FFF - 16'($urandom_range(0, 3)), 16'h8000, 16'h8000,
				rand_word(), rand_word(), rand_word(), rand_word());

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				set_ranges(2'd3, 2'd0);
			else if (ph == 1)
				set_ranges(2'd0, 2'd3);
			else
				set_ranges(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			idle_mode = ph % 4;
			if (ph == 2)
				hold_req = 1'b1;
			for (int n = 0; n < FRAMES_PER_PHASE; n++)
				send_random_frame();
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[imu_sample_scaler_calibrator] OK");
		else
			$display("[imu_sample_scaler_calibrator] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[imu_sample_scaler_calibrator] ERROR");
		$finish;
	end

endmodule
